@@ hw/rtl/amp_pkg.sv @@
package amp_pkg;

  localparam int DIM_W       = 11;
  localparam int COORD_W     = 10;
  localparam int CHAN_W      = 8;
  localparam int RND_W       = 8;
  localparam int NUM_W       = 23;
  localparam int CNT_W       = $clog2(NUM_W);
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int MAX_DIM_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_QST,
    S_QDIV,
    S_SETQ,
    S_MUL,
    S_CST,
    S_CDIV,
    S_SAVE,
    S_PST,
    S_PDIV,
    S_FFIX,
    S_IROW,
    S_RST,
    S_RDIV,
    S_ICOL,
    S_DONE
  } amp_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_GCD_STEP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SET_Q,
    OP_MUL,
    OP_SAVE_T,
    OP_FWD_FIX,
    OP_INV_ROW,
    OP_INV_COL,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    DS_FACTOR,
    DS_COL,
    DS_PROD,
    DS_ROW
  } div_src_t;

  typedef struct packed {
    dp_op_t   op;
    div_src_t src;
  } amp_cmd_t;

  typedef struct packed {
    logic oor;
    logic factor_ready;
    logic gcd_done;
    logic div_last;
    logic rnd_last;
    logic inverse;
  } amp_stat_t;

endpackage

@@ hw/rtl/amp_ctrl.sv @@
module amp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  amp_pkg::amp_stat_t stat,
  output amp_pkg::amp_cmd_t  cmd
);
  import amp_pkg::*;

  amp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.oor) state_nxt = S_DONE;
        else if (!stat.factor_ready) state_nxt = S_GCD;
        else state_nxt = S_MUL;
      end
      S_GCD:   if (stat.gcd_done) state_nxt = S_QST;
      S_QST:   state_nxt = S_QDIV;
      S_QDIV:  if (stat.div_last) state_nxt = S_SETQ;
      S_SETQ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = stat.inverse ? S_PST : S_CST;
      S_CST:   state_nxt = S_CDIV;
      S_CDIV:  if (stat.div_last) state_nxt = S_SAVE;
      S_SAVE:  state_nxt = S_PST;
      S_PST:   state_nxt = S_PDIV;
      S_PDIV:  if (stat.div_last) state_nxt = stat.inverse ? S_IROW : S_FFIX;
      S_FFIX:  state_nxt = stat.rnd_last ? S_DONE : S_MUL;
      S_IROW:  state_nxt = S_RST;
      S_RST:   state_nxt = S_RDIV;
      S_RDIV:  if (stat.div_last) state_nxt = S_ICOL;
      S_ICOL:  state_nxt = stat.rnd_last ? S_DONE : S_MUL;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op  = OP_IDLE;
    cmd.src = DS_FACTOR;
    case (state_r)
      S_IDLE:  if (in_tvalid) cmd.op = OP_LOAD;
      S_GCD:   cmd.op = OP_GCD_STEP;
      S_QST:   begin
        cmd.op  = OP_DIV_START;
        cmd.src = DS_FACTOR;
      end
      S_QDIV, S_CDIV, S_PDIV, S_RDIV: cmd.op = OP_DIV_STEP;
      S_SETQ:  cmd.op = OP_SET_Q;
      S_MUL:   cmd.op = OP_MUL;
      S_CST:   begin
        cmd.op  = OP_DIV_START;
        cmd.src = DS_COL;
      end
      S_SAVE:  cmd.op = OP_SAVE_T;
      S_PST:   begin
        cmd.op  = OP_DIV_START;
        cmd.src = DS_PROD;
      end
      S_FFIX:  cmd.op = OP_FWD_FIX;
      S_IROW:  cmd.op = OP_INV_ROW;
      S_RST:   begin
        cmd.op  = OP_DIV_START;
        cmd.src = DS_ROW;
      end
      S_ICOL:  cmd.op = OP_INV_COL;
      S_DONE:  if (out_free) cmd.op = OP_OUT;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHECK))
    else $error("accepted word did not start processing");

  a_oor_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && stat.oor) |=> (state_r == S_DONE))
    else $error("out of frame pixel went through the map");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not handed to output register");

endmodule

@@ hw/rtl/amp_dp.sv @@
module amp_dp #(
  parameter int MAX_DIM = amp_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [amp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic [amp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  input  logic [amp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [amp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  amp_pkg::amp_cmd_t                cmd,
  output amp_pkg::amp_stat_t               stat
);
  import amp_pkg::*;

  localparam int DIM_MAX_VAL = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIM > DIM_MAX_VAL) ? DIM_W'(DIM_MAX_VAL) : DIM_W'(MAX_DIM);
  localparam int PAD_W = OUT_TDATA_W - 2 * COORD_W - 3 * CHAN_W;

  // configuration
  logic [DIM_W-1:0] cfg_h_r, cfg_w_r;
  logic [RND_W-1:0] cfg_rnd_r;
  logic             cfg_inv_r;

  // working state
  logic [DIM_W-1:0]  q_r, a_r, b_r, y_r, x_r, t_r, d_r, rem_r;
  logic              factor_ready_r, oor_r;
  logic [NUM_W-1:0]  num_r, prod_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RND_W-1:0]  rnd_r;
  logic [CHAN_W-1:0] c0_r, c1_r, c2_r;

  // output register
  logic [COORD_W-1:0] dst_row_r, dst_col_r;
  logic [CHAN_W-1:0]  oc0_r, oc1_r, oc2_r;
  logic               oor_out_r;

  logic [DIM_W-1:0]   h, w;
  logic [COORD_W-1:0] src_row, src_col;
  logic               dim_wr;
  logic [DIM_W:0]     sum_xy, trial, row_sub, col_sub;
  logic [DIM_W:0]     mul_b;
  logic [NUM_W-1:0]   mul_res, start_num;
  logic [DIM_W-1:0]   start_div;
  logic               ge;

  assign h = (cfg_h_r > DIM_CAP) ? DIM_CAP : cfg_h_r;
  assign w = (cfg_w_r > DIM_CAP) ? DIM_CAP : cfg_w_r;

  assign src_row = in_tdata[COORD_W-1:0];
  assign src_col = in_tdata[2*COORD_W-1:COORD_W];
  assign dim_wr  = cfg_valid && (cfg_index == REG_HEIGHT || cfg_index == REG_WIDTH);

  assign sum_xy  = {1'b0, x_r} + {1'b0, y_r};
  assign mul_b   = cfg_inv_r ? {1'b0, x_r} : sum_xy;
  assign mul_res = NUM_W'(q_r) * NUM_W'(mul_b);

  assign trial   = {rem_r, num_r[NUM_W-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign row_sub = (y_r >= rem_r) ? {1'b0, y_r} - {1'b0, rem_r}
                                  : {1'b0, y_r} + {1'b0, h} - {1'b0, rem_r};
  assign col_sub = (x_r >= rem_r) ? {1'b0, x_r} - {1'b0, rem_r}
                                  : {1'b0, x_r} + {1'b0, w} - {1'b0, rem_r};

  always_comb begin
    case (cmd.src)
      DS_FACTOR: begin
        start_num = NUM_W'(h);
        start_div = a_r;
      end
      DS_COL: begin
        start_num = NUM_W'(sum_xy);
        start_div = w;
      end
      DS_PROD: begin
        start_num = cfg_inv_r ? prod_r : prod_r + NUM_W'(y_r);
        start_div = h;
      end
      DS_ROW: begin
        start_num = NUM_W'(y_r);
        start_div = w;
      end
      default: begin
        start_num = '0;
        start_div = h;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_h_r        <= DIM_W'(MAX_DIM_DEF);
      cfg_w_r        <= DIM_W'(MAX_DIM_DEF);
      cfg_rnd_r      <= RND_W'(1);
      cfg_inv_r      <= 1'b0;
      q_r            <= '0;
      factor_ready_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_HEIGHT:  cfg_h_r   <= cfg_data;
          REG_WIDTH:   cfg_w_r   <= cfg_data;
          REG_ROUNDS:  cfg_rnd_r <= cfg_data[RND_W-1:0];
          REG_INVERSE: cfg_inv_r <= cfg_data[0];
          default:     ;
        endcase
      end
      if (dim_wr) begin
        factor_ready_r <= 1'b0;
      end else if (cmd.op == OP_SET_Q) begin
        factor_ready_r <= 1'b1;
      end
      if (cmd.op == OP_SET_Q) begin
        q_r <= num_r[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        y_r   <= {1'b0, src_row};
        x_r   <= {1'b0, src_col};
        c0_r  <= in_tdata[2*COORD_W+CHAN_W-1:2*COORD_W];
        c1_r  <= in_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W];
        c2_r  <= in_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W];
        oor_r <= (h == '0) || (w == '0) ||
                 ({1'b0, src_row} >= h) || ({1'b0, src_col} >= w);
        a_r   <= h;
        b_r   <= w;
        rnd_r <= (cfg_rnd_r == '0) ? RND_W'(1) : cfg_rnd_r;
      end
      OP_GCD_STEP: begin
        if (a_r < b_r) begin
          a_r <= b_r - a_r;
          b_r <= a_r;
        end else begin
          a_r <= a_r - b_r;
        end
      end
      OP_DIV_START: begin
        num_r <= start_num;
        d_r   <= start_div;
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? DIM_W'(trial - {1'b0, d_r}) : trial[DIM_W-1:0];
        num_r <= {num_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_MUL:    prod_r <= mul_res;
      OP_SAVE_T: t_r <= rem_r;
      OP_FWD_FIX: begin
        y_r   <= rem_r;
        x_r   <= t_r;
        rnd_r <= rnd_r - RND_W'(1);
      end
      OP_INV_ROW: y_r <= row_sub[DIM_W-1:0];
      OP_INV_COL: begin
        x_r   <= col_sub[DIM_W-1:0];
        rnd_r <= rnd_r - RND_W'(1);
      end
      OP_OUT: begin
        dst_row_r <= oor_r ? '0 : y_r[COORD_W-1:0];
        dst_col_r <= oor_r ? '0 : x_r[COORD_W-1:0];
        oc0_r     <= c0_r;
        oc1_r     <= c1_r;
        oc2_r     <= c2_r;
        oor_out_r <= oor_r;
      end
      default: ;
    endcase
  end

  assign stat.oor          = oor_r;
  assign stat.factor_ready = factor_ready_r;
  assign stat.gcd_done     = (b_r == '0);
  assign stat.div_last     = (cnt_r == CNT_W'(NUM_W - 1));
  assign stat.rnd_last     = (rnd_r == RND_W'(1));
  assign stat.inverse      = cfg_inv_r;

  assign out_tdata = {{PAD_W{1'b0}}, oc2_r, oc1_r, oc0_r, dst_col_r, dst_row_r};
  assign out_tuser = oor_out_r;

  a_dim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    dim_wr |=> !factor_ready_r)
    else $error("frame size write left step factor marked valid");

  a_setq_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SET_Q && !dim_wr) |=> factor_ready_r)
    else $error("step factor not marked valid after update");

endmodule

@@ hw/rtl/arnold_map_pixel_address.sv @@
// channel  | direction | handshake              | payload
// in_      | slave     | in_tvalid / in_tready   | in_tdata: src_row, src_col, chan0..chan2
// out_     | master    | out_tvalid / out_tready | out_tdata: dst_row, dst_col, chans; tuser flag
// cfg_     | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// words are taken in one at a time; each round runs the shared restoring divider
// twice, plus multiply and fix-up steps
// after reset or a frame size write the next in-frame word first runs the gcd
// and then the division for the step factor
// out of frame words skip the map; reset is synchronous, active low
// a result waits in the output register while the next word is taken in
module arnold_map_pixel_address #(
  parameter int MAX_DIM = amp_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // src_row, src_col, chan0, chan1, chan2, zero pad
  input  logic [amp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // dst_row, dst_col, out_chan0, out_chan1, out_chan2, zero pad
  output logic [amp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_of_range
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [amp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [amp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import amp_pkg::*;

  amp_cmd_t  cmd;
  amp_stat_t stat;

  assign cfg_ready = 1'b1;

  amp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  amp_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
